>>> rtl/core/iath_pkg.sv
`default_nettype none

package iath_pkg;

   // Field widths of the two channels
   localparam int STAMP_W    = 64;
   localparam int BIN_W      = 3;
   localparam int SLOT_W     = 22;
   localparam int RESULT_W   = 32;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 64;

   // Decade bins: bins 0 to 4 have fixed depths, the last bin follows a parameter
   localparam int BIN_COUNT    = 6;
   localparam int FIXED_DEPTH  = 2120000;
   localparam int FIXED_QUOT_W = 20;
   localparam int BASE_W       = 22;
   localparam int LAST_DIVISOR = 10000000;
   localparam logic [BIN_W-1:0] LAST_BIN = 3'd5;

   // Slot unit: gap times a scaled reciprocal, built from four partial products
   localparam int RECIP_W = 48;
   localparam int PART_W  = 24;
   localparam int PROD_W  = 96;

   typedef enum logic [2:0] {
      STATUS_PRIMED    = 3'd0,
      STATUS_COUNTED   = 3'd1,
      STATUS_DROPPED   = 3'd2,
      STATUS_SATURATED = 3'd3,
      STATUS_READ      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      ACTION_STAMP = 1'b0,
      ACTION_READ  = 1'b1
   } action_type;

   // Start request for the slot unit
   typedef struct packed {
      logic             start;
      logic [BIN_W-1:0] bin;
   } div_req_type;

   // Reciprocal of each bin's resolution, rounded up after scaling by a power of two
   // (2^0, 2^27, 2^37, 2^47, 2^54, 2^71); exact over the gap range of the bin
   function automatic logic [RECIP_W-1:0] bin_recip(input logic [BIN_W-1:0] bin);
      logic [RECIP_W-1:0] m;
      unique case (bin)
         3'd0:    m = 48'd1;
         3'd1:    m = 48'd13421773;
         3'd2:    m = 48'd137438954;
         3'd3:    m = 48'd1407374884;
         3'd4:    m = 48'd18014398510;
         default: m = 48'd236118324143483;
      endcase
      return m;
   endfunction

   // First store entry of each bin
   function automatic logic [BASE_W-1:0] bin_base(input logic [BIN_W-1:0] bin);
      logic [BASE_W-1:0] b;
      unique case (bin)
         3'd0:    b = 22'd0;
         3'd1:    b = 22'd1000000;
         3'd2:    b = 22'd2000000;
         3'd3:    b = 22'd2100000;
         3'd4:    b = 22'd2110000;
         default: b = 22'd2120000;
      endcase
      return b;
   endfunction

   // Depth of the fixed bins; the last bin is sized by the top level
   function automatic logic [FIXED_QUOT_W-1:0] fixed_depth(input logic [BIN_W-1:0] bin);
      logic [FIXED_QUOT_W-1:0] n;
      unique case (bin)
         3'd0, 3'd1: n = 20'd1000000;
         3'd2:       n = 20'd100000;
         3'd3, 3'd4: n = 20'd10000;
         default:    n = 20'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/interarrival_time_histogram.sv
`default_nettype none
// Inter-arrival time histogram.
// Request beats arrive on req_*: tuser = 0 carries a timestamp in 100 ns units, tuser = 1
// asks for one histogram counter (bin and slot in tdata). Every request beat gives exactly
// one result beat on rsp_*, in order, whose tuser holds the status.
// Timestamps: the first one primes the kept stamp, an older one is dropped, any other one
// counts its gap in a saturating counter in one of six decade bins of the counter memory.
// One request is worked on at a time. A counted event passes through the slot unit, which
// multiplies the gap by the bin's scaled reciprocal as four 24 x 24 partial products. A
// gap beyond the last bin skips the multiply. A read goes through the registered memory
// read, a priming beat goes straight to the result and a dropped beat leaves after the gap
// check. Each counter is read, incremented and written back before the next request is
// taken, so accesses to one counter never overlap.
// After reset the counter memory is cleared one entry a cycle, all 2120000 + LAST_BIN_DEPTH
// entries (4798400 at the default), with req_tready low. rsp_tvalid drops at reset.
// The result sits in an output register: a stalled receiver holds it while the next
// request is accepted and worked on; that request then waits for the register to free.
module interarrival_time_histogram
   import iath_pkg::*;
#(
   parameter int COUNT_WIDTH    = 32,
   parameter int LAST_BIN_DEPTH = 2678400
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire [REQ_DATA_W-1:0]  req_tdata,   // stamp[63:0], read_bin[66:64], read_slot[88:67]
   input  wire                   req_tuser,   // action[0]
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // bin[2:0], slot[24:3], count[56:25]
   output logic [2:0]            rsp_tuser    // status[2:0]
);

   localparam int STORE_DEPTH = FIXED_DEPTH + LAST_BIN_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [STAMP_W-1:0] SAT_LIMIT =
      STAMP_W'(LAST_BIN_DEPTH) * STAMP_W'(LAST_DIVISOR);
   localparam int DIV_W  = $clog2(SAT_LIMIT);
   localparam int QUOT_W = ($clog2(LAST_BIN_DEPTH) > FIXED_QUOT_W) ?
                           $clog2(LAST_BIN_DEPTH) : FIXED_QUOT_W;
   localparam int RSP_PAD_W = RSP_DATA_W - RESULT_W - SLOT_W - BIN_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_GAP, ST_CLASS, ST_DIV, ST_ISSUE, ST_UPDATE, ST_DONE
   } state_type;

   state_type               state_ff;
   action_type              action_ff;
   logic [STAMP_W-1:0]      stamp_ff;
   logic [STAMP_W-1:0]      prev_stamp_ff;
   logic                    prev_valid_ff;
   logic [STAMP_W-1:0]      gap_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic                    rd_ok_ff;
   status_type              res_status_ff;
   logic [BIN_W-1:0]        res_bin_ff;
   logic [SLOT_W-1:0]       res_slot_ff;
   logic [RESULT_W-1:0]     res_count_ff;
   logic                    rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff;
   status_type              rsp_tuser_ff;
   logic [COUNT_WIDTH-1:0]  mem_rdata_ff;
   logic [COUNT_WIDTH-1:0]  counter_mem [STORE_DEPTH];

   logic [BIN_W-1:0]        rd_bin_in;
   logic [SLOT_W-1:0]       rd_slot_in;
   logic                    rd_ok_in;
   logic [ADDR_W-1:0]       rd_addr_in;
   logic [STAMP_W:0]        diff_in;
   logic [BIN_W-1:0]        bin_in;
   logic                    sat_in;
   logic [ADDR_W-1:0]       quot_addr_in;
   logic [COUNT_WIDTH-1:0]  cell_in;
   logic                    mem_we_in;
   logic [COUNT_WIDTH-1:0]  mem_wdata_in;
   logic                    out_free_in;
   div_req_type             div_req;
   logic                    div_done;
   logic [QUOT_W-1:0]       div_quot;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign out_free_in = !rsp_tvalid_ff || rsp_tready;

   // Range check and address of a read request
   assign rd_bin_in  = req_tdata[66:64];
   assign rd_slot_in = req_tdata[88:67];

   always_comb begin
      priority if (rd_bin_in > LAST_BIN) begin
         rd_ok_in = 1'b0;
      end else if (rd_bin_in == LAST_BIN) begin
         rd_ok_in = 32'(rd_slot_in) < 32'(LAST_BIN_DEPTH);
      end else begin
         rd_ok_in = rd_slot_in < SLOT_W'(fixed_depth(rd_bin_in));
      end
      rd_addr_in = rd_ok_in ? ADDR_W'(32'(bin_base(rd_bin_in)) + 32'(rd_slot_in)) : '0;
   end

   // Gap to the kept stamp; the borrow marks an out-of-order stamp
   assign diff_in = {1'b0, stamp_ff} - {1'b0, prev_stamp_ff};

   // Decade bin of the registered gap
   always_comb begin
      priority if (gap_ff < 64'd1000000) begin
         bin_in = 3'd0;
      end else if (gap_ff < 64'd10000000) begin
         bin_in = 3'd1;
      end else if (gap_ff < 64'd100000000) begin
         bin_in = 3'd2;
      end else if (gap_ff < 64'd1000000000) begin
         bin_in = 3'd3;
      end else if (gap_ff < 64'd10000000000) begin
         bin_in = 3'd4;
      end else begin
         bin_in = LAST_BIN;
      end
   end

   assign sat_in = gap_ff >= SAT_LIMIT;

   // Slot within the bin: gap divided by the bin's resolution
   assign div_req = '{start: (state_ff == ST_CLASS) && !sat_in, bin: bin_in};

   iath_div #(
      .DIVIDEND_W (DIV_W),
      .QUOT_W     (QUOT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .dividend (gap_ff[DIV_W-1:0]),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign quot_addr_in = ADDR_W'(32'(bin_base(res_bin_ff)) + 32'(div_quot));

   // Saturating increment and memory write, or zero fill while clearing
   assign cell_in      = (mem_rdata_ff == COUNT_MAX) ? mem_rdata_ff : mem_rdata_ff + 1'b1;
   assign mem_we_in    = (state_ff == ST_CLEAR) ||
                         ((state_ff == ST_UPDATE) && (action_ff == ACTION_STAMP));
   assign mem_wdata_in = (state_ff == ST_CLEAR) ? '0 : cell_in;

   // Counter memory, one read and one write port
   always_ff @(posedge clock) begin
      if (mem_we_in) begin
         counter_mem[addr_ff] <= mem_wdata_in;
      end
      mem_rdata_ff <= counter_mem[addr_ff];
   end

   // Output register: load a finished beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free_in) begin
         rsp_tvalid_ff <= 1'b1;
         rsp_tdata_ff  <= {{RSP_PAD_W{1'b0}}, res_count_ff, res_slot_ff, res_bin_ff};
         rsp_tuser_ff  <= res_status_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         addr_ff       <= '0;
         prev_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
                  addr_ff  <= '0;
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  action_ff <= action_type'(req_tuser);
                  stamp_ff  <= req_tdata[STAMP_W-1:0];
                  if (action_type'(req_tuser) == ACTION_READ) begin
                     res_status_ff <= STATUS_READ;
                     res_bin_ff    <= rd_bin_in;
                     res_slot_ff   <= rd_slot_in;
                     rd_ok_ff      <= rd_ok_in;
                     addr_ff       <= rd_addr_in;
                     state_ff      <= ST_ISSUE;
                  end else if (!prev_valid_ff) begin
                     prev_stamp_ff <= req_tdata[STAMP_W-1:0];
                     prev_valid_ff <= 1'b1;
                     res_status_ff <= STATUS_PRIMED;
                     res_bin_ff    <= '0;
                     res_slot_ff   <= '0;
                     res_count_ff  <= '0;
                     state_ff      <= ST_DONE;
                  end else begin
                     state_ff <= ST_GAP;
                  end
               end
            end
            ST_GAP: begin
               if (diff_in[STAMP_W]) begin
                  // drop an older stamp, keep the previous one
                  res_status_ff <= STATUS_DROPPED;
                  res_bin_ff    <= '0;
                  res_slot_ff   <= '0;
                  res_count_ff  <= '0;
                  state_ff      <= ST_DONE;
               end else begin
                  gap_ff        <= diff_in[STAMP_W-1:0];
                  prev_stamp_ff <= stamp_ff;
                  state_ff      <= ST_CLASS;
               end
            end
            ST_CLASS: begin
               res_bin_ff <= bin_in;
               if (sat_in) begin
                  // clamp to the top entry of the last bin
                  res_status_ff <= STATUS_SATURATED;
                  res_slot_ff   <= SLOT_W'(LAST_BIN_DEPTH - 1);
                  addr_ff       <= ADDR_W'(STORE_DEPTH - 1);
                  state_ff      <= ST_ISSUE;
               end else begin
                  res_status_ff <= STATUS_COUNTED;
                  state_ff      <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  res_slot_ff <= SLOT_W'(div_quot);
                  addr_ff     <= quot_addr_in;
                  state_ff    <= ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (action_ff == ACTION_READ) begin
                  res_count_ff <= rd_ok_ff ? RESULT_W'(mem_rdata_ff) : '0;
               end else begin
                  res_count_ff <= RESULT_W'(cell_in);
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free_in) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/iath_div.sv
`default_nettype none

module iath_div
   import iath_pkg::*;
#(
   parameter int DIVIDEND_W = 45,
   parameter int QUOT_W     = 22
) (
   input  wire                  clock,
   input  wire                  reset,
   input  div_req_type          div_req,
   input  wire [DIVIDEND_W-1:0] dividend,
   output logic                 done,
   output logic [QUOT_W-1:0]    quotient
);

   localparam logic [1:0] LAST_PHASE = 2'd3;

   logic                  busy_ff;
   logic                  done_ff;
   logic [1:0]            phase_ff;
   logic [BIN_W-1:0]      bin_ff;
   logic [RECIP_W-1:0]    num_ff;
   logic [RECIP_W-1:0]    recip_ff;
   logic [PROD_W-1:0]     acc_ff;
   logic [PART_W-1:0]     num_part_in;
   logic [PART_W-1:0]     recip_part_in;
   logic [2*PART_W-1:0]   part_prod_in;
   logic [PROD_W-1:0]     acc_in;
   logic [QUOT_W-1:0]     quot_in;

   assign done     = done_ff;
   assign quotient = quot_in;

   // One 24 x 24 partial product a cycle: low by low, low by high, high by low, high by high
   assign num_part_in   = phase_ff[1] ? num_ff[RECIP_W-1:PART_W] : num_ff[PART_W-1:0];
   assign recip_part_in = phase_ff[0] ? recip_ff[RECIP_W-1:PART_W] : recip_ff[PART_W-1:0];
   assign part_prod_in  = num_part_in * recip_part_in;

   // Add the partial product at its weight
   always_comb begin
      unique case (phase_ff)
         2'd0:       acc_in = acc_ff + {{2*PART_W{1'b0}}, part_prod_in};
         LAST_PHASE: acc_in = acc_ff + {part_prod_in, {2*PART_W{1'b0}}};
         default:    acc_in = acc_ff + {{PART_W{1'b0}}, part_prod_in, {PART_W{1'b0}}};
      endcase
   end

   // Drop the scaling of the reciprocal
   always_comb begin
      unique case (bin_ff)
         3'd0:    quot_in = acc_ff[QUOT_W-1:0];
         3'd1:    quot_in = acc_ff[27 +: QUOT_W];
         3'd2:    quot_in = acc_ff[37 +: QUOT_W];
         3'd3:    quot_in = acc_ff[47 +: QUOT_W];
         3'd4:    quot_in = acc_ff[54 +: QUOT_W];
         default: quot_in = acc_ff[71 +: QUOT_W];
      endcase
   end

   // Load on start, then accumulate the partial products while busy, and raise done after the last phase
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= '0;
      end else begin
         done_ff <= busy_ff && (phase_ff == LAST_PHASE);
         if (div_req.start) begin
            busy_ff  <= 1'b1;
            phase_ff <= '0;
            bin_ff   <= div_req.bin;
            num_ff   <= RECIP_W'(dividend);
            recip_ff <= bin_recip(div_req.bin);
            acc_ff   <= '0;
         end else if (busy_ff) begin
            acc_ff   <= acc_in;
            phase_ff <= phase_ff + 1'b1;
            if (phase_ff == LAST_PHASE) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/iath_checker.sv
`default_nettype none

module iath_checker
   import iath_pkg::*;
(
   input wire                  clock,
   input wire                  reset,
   input wire                  req_tvalid,
   input wire                  req_tready,
   input wire [REQ_DATA_W-1:0] req_tdata,
   input wire                  req_tuser,
   input wire                  rsp_tvalid,
   input wire                  rsp_tready,
   input wire [RSP_DATA_W-1:0] rsp_tdata,
   input wire [2:0]            rsp_tuser
);

   // Reset empties the output and blocks requests during the clearing pass
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("output or request side active after reset");

   // Priming and dropped beats carry no bin, slot or count
   a_empty_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_PRIMED || rsp_tuser == STATUS_DROPPED)
      |-> rsp_tdata == '0)
      else $error("primed or dropped beat with non-zero payload");

   // Only the last bin saturates
   a_sat_last_bin: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_SATURATED |-> rsp_tdata[BIN_W-1:0] == LAST_BIN)
      else $error("saturated beat outside the last bin");

   // One request in flight: no acceptance in the cycle after one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind interarrival_time_histogram iath_checker u_iath_checker (.*);

`default_nettype wire

>>> tb/iath_histogram_checker.sv
`default_nettype none

module iath_histogram_checker
   import iath_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   input  wire                   req_tready,
   input  wire [REQ_DATA_W-1:0]  req_tdata,   // stamp[63:0], read_bin[66:64], read_slot[88:67]
   input  wire                   req_tuser,   // action[0]
   input  wire                   rsp_tvalid,
   input  wire                   rsp_tready,
   input  wire [RSP_DATA_W-1:0]  rsp_tdata,   // bin[2:0], slot[24:3], count[56:25]
   input  wire [2:0]             rsp_tuser,   // status[2:0]
   output int                    mismatch_count,
   output int                    outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LAST_DEPTH = 2678400;
   localparam int NUM_BINS   = 6;

   typedef struct {
      status_type  status;
      logic [2:0]  bin_no;
      logic [21:0] slot_no;
      logic [31:0] count;
   } hist_outcome;

   // Predicted histogram state
   logic [63:0] kept_stamp = '0;
   logic        kept_valid = 1'b0;
   logic [31:0] hist_counts [int];

   hist_outcome pending_outcomes [$];

   // Entries per decade bin
   function automatic int depth_of(input logic [2:0] b);
      case (b)
         3'd0, 3'd1: return 1000000;
         3'd2:       return 100000;
         3'd3, 3'd4: return 10000;
         default:    return LAST_DEPTH;
      endcase
   endfunction

   // Flat counter index of the first entry of a bin
   function automatic int first_entry_of(input logic [2:0] b);
      case (b)
         3'd0:    return 0;
         3'd1:    return 1000000;
         3'd2:    return 2000000;
         3'd3:    return 2100000;
         3'd4:    return 2110000;
         default: return 2120000;
      endcase
   endfunction

   // Work out the response to one request beat and advance the predicted state
   function automatic hist_outcome predict_outcome(input action_type act,
                                                   input logic [63:0] stamp,
                                                   input logic [2:0] rbin,
                                                   input logic [21:0] rslot);
      hist_outcome o;
      logic [63:0] gap;
      logic [63:0] q;
      logic [63:0] slot_wide;
      logic [31:0] cnt;
      int key;
      o.status  = STATUS_READ;
      o.bin_no  = rbin;
      o.slot_no = rslot;
      o.count   = '0;
      if (act == ACTION_READ) begin
         if (rbin < NUM_BINS && int'(rslot) < depth_of(rbin)) begin
            key = first_entry_of(rbin) + int'(rslot);
            if (hist_counts.exists(key)) o.count = hist_counts[key];
         end
         return o;
      end
      o.bin_no  = '0;
      o.slot_no = '0;
      if (!kept_valid) begin
         kept_stamp = stamp;
         kept_valid = 1'b1;
         o.status   = STATUS_PRIMED;
         return o;
      end
      if (stamp < kept_stamp) begin
         o.status = STATUS_DROPPED;
         return o;
      end
      gap      = stamp - kept_stamp;
      q        = gap / 64'd1000000;
      o.status = STATUS_COUNTED;
      // sort the gap into its decade
      if (q < 64'd1) begin
         o.bin_no = 3'd0; slot_wide = gap;
      end else if (q < 64'd10) begin
         o.bin_no = 3'd1; slot_wide = gap / 64'd10;
      end else if (q < 64'd100) begin
         o.bin_no = 3'd2; slot_wide = gap / 64'd1000;
      end else if (q < 64'd1000) begin
         o.bin_no = 3'd3; slot_wide = gap / 64'd100000;
      end else if (q < 64'd10000) begin
         o.bin_no = 3'd4; slot_wide = q;
      end else begin
         o.bin_no  = LAST_BIN;
         slot_wide = q / 64'd10;
         if (slot_wide >= 64'(LAST_DEPTH)) begin
            slot_wide = 64'(LAST_DEPTH - 1);
            o.status  = STATUS_SATURATED;
         end
      end
      key = first_entry_of(o.bin_no) + int'(slot_wide);
      cnt = hist_counts.exists(key) ? hist_counts[key] : '0;
      if (cnt != '1) cnt = cnt + 1'b1;
      hist_counts[key] = cnt;
      kept_stamp = stamp;
      o.slot_no  = slot_wide[21:0];
      o.count    = cnt;
      return o;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Pop and compare each response beat, then predict each request beat
   always @(posedge clock) begin
      hist_outcome want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: response beat with nothing expected, status %0d count %0d",
                        $time, rsp_tuser, rsp_tdata[56:25]);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_tuser));
               compare_field("bin", 32'(want.bin_no), 32'(rsp_tdata[2:0]));
               compare_field("slot", 32'(want.slot_no), 32'(rsp_tdata[24:3]));
               compare_field("count", want.count, rsp_tdata[56:25]);
            end
         end
         if (req_tvalid && req_tready)
            pending_outcomes.push_back(predict_outcome(action_type'(req_tuser),
                                                       req_tdata[63:0],
                                                       req_tdata[66:64],
                                                       req_tdata[88:67]));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

`default_nettype wire

>>> tb/tb_interarrival_time_histogram.sv
`default_nettype none

module tb_interarrival_time_histogram;
   timeunit 1ns;
   timeprecision 1ps;
   import iath_pkg::*;

   localparam int          PHASE_BEATS   = 345;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          CLEAR_TIMEOUT = 20000000;
   localparam int          RUN_TIMEOUT   = 5000;
   localparam int          DRAIN_CYCLES  = 40;
   localparam logic [63:0] SATURATE_GAP  = 64'd26784000000000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // stamp[63:0], read_bin[66:64], read_slot[88:67]
   logic                  req_tuser;   // action[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // bin[2:0], slot[24:3], count[56:25]
   logic [2:0]            rsp_tuser;   // status[2:0]

   int mismatch_count;
   int outstanding;

   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   int          hold_requests      = 0;
   int          holds_served       = 0;
   logic [63:0] last_stamp         = '0;

   always #1 clock = ~clock;

   interarrival_time_histogram i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   iath_histogram_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Offer one beat at the falling edge and hold it until accepted
   task automatic send_beat(input action_type act, input logic [63:0] stamp,
                            input logic [2:0] rbin, input logic [21:0] rslot);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {7'd0, rslot, rbin, stamp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_gap(input logic [63:0] gap);
      last_stamp = last_stamp + gap;
      send_beat(ACTION_STAMP, last_stamp, 3'($urandom), 22'($urandom));
   endtask

   task automatic send_read(input logic [2:0] rbin, input logic [21:0] rslot);
      send_beat(ACTION_READ, rand64(), rbin, rslot);
   endtask

   // Many small gaps so counters repeat, every decade, boundaries and saturation
   function automatic logic [63:0] pick_gap();
      int c;
      c = $urandom_range(99);
      if (c < 30)      return 64'($urandom_range(7));
      else if (c < 45) return 64'($urandom_range(999999));
      else if (c < 57) return 64'd1000000 + 64'($urandom_range(8999999));
      else if (c < 66) return 64'd10000000 + 64'($urandom_range(89999999));
      else if (c < 74) return 64'd100000000 + rand64() % 64'd900000000;
      else if (c < 82) return 64'd1000000000 + rand64() % 64'd9000000000;
      else if (c < 90) return 64'd10000000000 + rand64() % (SATURATE_GAP - 64'd10000000000);
      else if (c < 96) begin
         case ($urandom_range(3))
            0:       return 64'd1000000 + 64'($urandom_range(9));
            1:       return 64'd9999990 + 64'($urandom_range(9));
            2:       return 64'd999999;
            default: return SATURATE_GAP - 64'd1 - 64'($urandom_range(9999999));
         endcase
      end
      return SATURATE_GAP + rand64() % (64'd1 << 50);
   endfunction

   // Random mix of reads, late stamps and counted gaps
   task automatic run_phase(input int beats, input int idle_pct, input int stall_pct,
                            input bit with_hold);
      int c;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < beats; n++) begin
         if (with_hold && n == 20) hold_requests++;
         c = $urandom_range(99);
         if (c < 18) begin
            case ($urandom_range(9))
               0, 1, 2, 3: send_read(3'd0, 22'($urandom_range(7)));
               4, 5: begin
                  case ($urandom_range(3))
                     0:       send_read(3'd1, 22'd100000);
                     1:       send_read(3'd1, 22'd999999);
                     2:       send_read(LAST_BIN, 22'd2678399);
                     default: send_read(3'd0, 22'd999999);
                  endcase
               end
               6, 7: send_read(3'($urandom_range(5)), 22'($urandom_range(9999)));
               8:    send_read(3'($urandom_range(7, 6)), 22'($urandom));
               default: send_read(3'($urandom), 22'($urandom));
            endcase
         end else if (c < 26) begin
            send_beat(ACTION_STAMP, last_stamp - (rand64() % last_stamp) - 64'd1,
                      3'($urandom), 22'($urandom));
         end else begin
            send_gap(pick_gap());
         end
      end
   endtask

   // Receiver: random stalls, and a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_served) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_served++;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: long allowance while the counter store clears, short one after
   initial begin
      int idle_cycles;
      bit seen_beat;
      idle_cycles = 0;
      seen_beat   = 1'b0;
      while (idle_cycles < (seen_beat ? RUN_TIMEOUT : CLEAR_TIMEOUT)) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
            seen_beat   = 1'b1;
         end else begin
            idle_cycles++;
         end
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = ACTION_STAMP;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // read before anything is seen, then prime
      send_read(3'd0, 22'd0);
      send_gap(64'd1000);
      // equal stamp, late stamps, zero stamp
      send_gap(64'd0);
      send_beat(ACTION_STAMP, last_stamp - 64'd1, 3'd0, 22'd0);
      send_beat(ACTION_STAMP, 64'd0, 3'd7, 22'h3FFFFF);
      // both edges of every decade
      send_gap(64'd999999);
      send_gap(64'd1000000);
      send_gap(64'd9999999);
      send_gap(64'd10000000);
      send_gap(64'd99999999);
      send_gap(64'd100000000);
      send_gap(64'd999999999);
      send_gap(64'd1000000000);
      send_gap(64'd9999999999);
      send_gap(64'd10000000000);
      send_gap(SATURATE_GAP - 64'd1);
      send_gap(SATURATE_GAP);
      send_gap(64'd0);
      // read back, then out-of-range reads
      send_read(3'd0, 22'd0);
      send_read(LAST_BIN, 22'd2678399);
      send_read(3'd6, 22'd0);
      send_read(3'd7, 22'h3FFFFF);
      send_read(3'd0, 22'd1000000);
      send_read(LAST_BIN, 22'd2678400);

      run_phase(PHASE_BEATS, 0, 0, 1'b1);
      run_phase(PHASE_BEATS, 54, 0, 1'b0);
      run_phase(PHASE_BEATS, 0, 54, 1'b0);
      run_phase(PHASE_BEATS, 25, 25, 1'b0);

      // all-ones stamp last, since no later stamp can follow it
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_beat(ACTION_STAMP, '1, 3'd0, 22'd0);
      send_beat(ACTION_STAMP, 64'd0, 3'd0, 22'd0);
      send_beat(ACTION_STAMP, '1, 3'd7, 22'h3FFFFF);
      send_read(LAST_BIN, 22'd2678399);
      req_tvalid <= 1'b0;

      // drain the remaining responses
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/iath_pkg.sv
rtl/core/iath_div.sv
rtl/core/interarrival_time_histogram.sv
rtl/core/iath_checker.sv
tb/iath_histogram_checker.sv
tb/tb_interarrival_time_histogram.sv
